@@ rtl/amaq_pkg.sv @@
// Shared types and constants for the accel/mag attitude quaternion block.
`default_nettype none
package amaq_pkg;
  localparam int unsigned AxisW = 16;
  localparam int unsigned QW = 16;
  // Cross products: east < 2^32 (34b signed), north < 2^49 (50b signed)
  localparam int unsigned EastW = 34;
  localparam int unsigned NorthW = 50;
  // Magnitudes after range reduction stay below 2^31
  localparam int unsigned MagW = 31;
  localparam int unsigned SumW = 64;
  localparam int unsigned RootW = 32;

  typedef struct packed {
    logic signed [AxisW-1:0] ax, ay, az, mx, my, mz;
  } sens_t;

  typedef struct packed {
    logic signed [QW-1:0] w, x, y, z;
    logic degenerate;
  } quat_t;
endpackage
`default_nettype wire

@@ rtl/amaq_isqrt.sv @@
// Pipelined integer square root, two result bits per stage.
`default_nettype none
module amaq_isqrt #(
  parameter int unsigned InW = 64,
  parameter int unsigned TagW = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic [InW-1:0]        x,
  input  wire logic [TagW-1:0]       tag_in,
  output logic                       out_valid,
  output logic [InW/2-1:0]           root,
  output logic [TagW-1:0]            tag_out
);
  localparam int unsigned RW = InW / 2;
  localparam int unsigned Steps = RW / 2;

  logic [InW-1:0] rem [Steps+1];
  logic [RW-1:0]  res [Steps+1];
  logic [InW-1:0] xs  [Steps+1];
  logic [TagW-1:0] tg [Steps+1];
  logic           vld [Steps+1];

  assign rem[0] = '0;
  assign res[0] = '0;
  assign xs[0]  = x;
  assign tg[0]  = tag_in;
  assign vld[0] = in_valid;

  for (genvar s = 0; s < Steps; s++) begin : g_stage
    logic [InW-1:0] r_n, x_n, r_t;
    logic [RW-1:0] q_t;
    always_comb begin
      r_t = rem[s];
      q_t = res[s];
      x_n = xs[s];
      for (int b = 0; b < 2; b++) begin
        // restoring digit: try (4q+1) against remainder
        logic [InW+1:0] trial;
        logic [InW+1:0] cand;
        trial = {r_t, x_n[InW-1 -: 2]};
        cand = {{(InW-RW){1'b0}}, q_t, 2'b01};
        x_n = {x_n[InW-3:0], 2'b00};
        if (trial >= cand) begin
          r_t = InW'(trial - cand);
          q_t = {q_t[RW-2:0], 1'b1};
        end else begin
          r_t = InW'(trial);
          q_t = {q_t[RW-2:0], 1'b0};
        end
      end
      r_n = r_t;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
      if (en) begin
        rem[s+1] <= r_n;
        res[s+1] <= q_t;
        xs[s+1]  <= x_n;
        tg[s+1]  <= tg[s];
      end
    end
  end

  assign out_valid = vld[Steps];
  assign root = res[Steps];
  assign tag_out = tg[Steps];
endmodule
`default_nettype wire

@@ rtl/amaq_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module amaq_div #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 33,
  parameter int unsigned TagW = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [NumW-1:0]  num,
  input  wire logic [DenW-1:0]  den,
  input  wire logic [TagW-1:0]  tag_in,
  output logic                  out_valid,
  output logic [NumW-1:0]       quo,
  output logic [TagW-1:0]       tag_out
);
  logic [DenW-1:0] rem [NumW+1];
  logic [NumW-1:0] q   [NumW+1];
  logic [DenW-1:0] d   [NumW+1];
  logic [TagW-1:0] tg  [NumW+1];
  logic            vld [NumW+1];

  assign rem[0] = '0;
  assign q[0]   = num;
  assign d[0]   = den;
  assign tg[0]  = tag_in;
  assign vld[0] = in_valid;

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic [DenW:0] trial;
    logic [DenW-1:0] r_n;
    logic [NumW-1:0] q_n;
    always_comb begin
      trial = {rem[s], q[s][NumW-1]};
      if (trial >= {1'b0, d[s]}) begin
        r_n = DenW'(trial - {1'b0, d[s]});
        q_n = {q[s][NumW-2:0], 1'b1};
      end else begin
        r_n = DenW'(trial);
        q_n = {q[s][NumW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
      if (en) begin
        rem[s+1] <= r_n;
        q[s+1]   <= q_n;
        d[s+1]   <= d[s];
        tg[s+1]  <= tg[s];
      end
    end
  end

  assign out_valid = vld[NumW];
  assign quo = q[NumW];
  assign tag_out = tg[NumW];
endmodule
`default_nettype wire

@@ rtl/amaq_unit_row.sv @@
// Normalizes one signed vector to a unit row (range reduce, sqrt, divide).
`default_nettype none
module amaq_unit_row #(
  parameter int unsigned VecW = 50,
  parameter int unsigned FracBits = 15,
  parameter int unsigned TagW = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire logic signed [VecW-1:0]     v0,
  input  wire logic signed [VecW-1:0]     v1,
  input  wire logic signed [VecW-1:0]     v2,
  input  wire logic [TagW-1:0]            tag_in,
  output logic                            out_valid,
  output logic signed [FracBits+2:0]      u0,
  output logic signed [FracBits+2:0]      u1,
  output logic signed [FracBits+2:0]      u2,
  output logic                            zero,
  output logic [TagW-1:0]                 tag_out
);
  import amaq_pkg::*;
  localparam int unsigned NumW = MagW + FracBits + 1;
  localparam int unsigned UW = FracBits + 3;
  localparam int unsigned SqW = TagW + 3 + 3 * MagW;

  // stage 1: magnitudes and signs
  logic [VecW-1:0] mg0, mg1, mg2, mxv;
  logic [2:0] sg1;
  logic v1r;
  logic [TagW-1:0] tg1;
  always_ff @(posedge clk) begin
    if (rst) v1r <= 1'b0;
    else if (en) v1r <= in_valid;
    if (en) begin
      mg0 <= v0[VecW-1] ? VecW'(-v0) : VecW'(v0);
      mg1 <= v1[VecW-1] ? VecW'(-v1) : VecW'(v1);
      mg2 <= v2[VecW-1] ? VecW'(-v2) : VecW'(v2);
      sg1 <= {v2[VecW-1], v1[VecW-1], v0[VecW-1]};
      tg1 <= tag_in;
    end
  end

  // stage 2: shift count from the largest magnitude, then shift
  logic [MagW-1:0] s0, s1, s2;
  logic [2:0] sg2;
  logic v2r;
  logic [TagW-1:0] tg2;
  logic [VecW-1:0] m01, mmax;
  int unsigned kk;
  always_comb begin
    m01 = (mg1 > mg0) ? mg1 : mg0;
    mmax = (mg2 > m01) ? mg2 : m01;
    kk = 0;
    for (int b = VecW - 1; b >= MagW; b--) begin
      if (kk == 0 && mmax[b]) kk = b - MagW + 1;
    end
  end
  assign mxv = mmax;
  always_ff @(posedge clk) begin
    if (rst) v2r <= 1'b0;
    else if (en) v2r <= v1r;
    if (en) begin
      s0 <= MagW'(mg0 >> kk);
      s1 <= MagW'(mg1 >> kk);
      s2 <= MagW'(mg2 >> kk);
      sg2 <= sg1;
      tg2 <= tg1;
    end
  end

  // stage 3: squares
  logic [61:0] p0, p1, p2;
  logic [MagW-1:0] s0r, s1r, s2r;
  logic [2:0] sg3;
  logic v3r;
  logic [TagW-1:0] tg3;
  always_ff @(posedge clk) begin
    if (rst) v3r <= 1'b0;
    else if (en) v3r <= v2r;
    if (en) begin
      p0 <= s0 * s0;
      p1 <= s1 * s1;
      p2 <= s2 * s2;
      s0r <= s0; s1r <= s1; s2r <= s2;
      sg3 <= sg2;
      tg3 <= tg2;
    end
  end

  logic [SumW-1:0] ssum;
  assign ssum = SumW'(p0) + SumW'(p1) + SumW'(p2);

  logic sq_v;
  logic [RootW-1:0] nrm;
  logic [SqW-1:0] sq_tag;
  amaq_isqrt #(.InW(SumW), .TagW(SqW)) u_sqrt (
    .clk, .rst, .en, .in_valid(v3r), .x(ssum),
    .tag_in({tg3, sg3, s2r, s1r, s0r}),
    .out_valid(sq_v), .root(nrm), .tag_out(sq_tag)
  );

  logic [MagW-1:0] t0, t1, t2;
  logic [2:0] sgq;
  logic [TagW-1:0] tgq;
  assign {tgq, sgq, t2, t1, t0} = sq_tag;

  // three dividers share the denominator; numerators get n/2 for rounding
  logic [NumW-1:0] n0, n1, n2, q0, q1, q2;
  logic [RootW-1:0] half;
  assign half = nrm >> 1;
  assign n0 = NumW'({t0, FracBits'(0)}) + NumW'(half);
  assign n1 = NumW'({t1, FracBits'(0)}) + NumW'(half);
  assign n2 = NumW'({t2, FracBits'(0)}) + NumW'(half);

  logic dv0, dv1, dv2;
  logic [TagW+3:0] dt0, dt1, dt2;
  logic [RootW-1:0] dn;
  assign dn = (nrm == '0) ? RootW'(1) : nrm;
  amaq_div #(.NumW(NumW), .DenW(RootW), .TagW(TagW + 4)) u_d0 (
    .clk, .rst, .en, .in_valid(sq_v), .num(n0), .den(dn),
    .tag_in({tgq, sgq, nrm == '0}), .out_valid(dv0), .quo(q0), .tag_out(dt0));
  amaq_div #(.NumW(NumW), .DenW(RootW), .TagW(TagW + 4)) u_d1 (
    .clk, .rst, .en, .in_valid(sq_v), .num(n1), .den(dn),
    .tag_in({tgq, sgq, nrm == '0}), .out_valid(dv1), .quo(q1), .tag_out(dt1));
  amaq_div #(.NumW(NumW), .DenW(RootW), .TagW(TagW + 4)) u_d2 (
    .clk, .rst, .en, .in_valid(sq_v), .num(n2), .den(dn),
    .tag_in({tgq, sgq, nrm == '0}), .out_valid(dv2), .quo(q2), .tag_out(dt2));

  // quotients are at most 2^FracBits plus rounding slack
  assign out_valid = dv0;
  assign u0 = dt0[1] ? -$signed(UW'(q0)) : $signed(UW'(q0));
  assign u1 = dt0[2] ? -$signed(UW'(q1)) : $signed(UW'(q1));
  assign u2 = dt0[3] ? -$signed(UW'(q2)) : $signed(UW'(q2));
  assign zero = dt0[0];
  assign tag_out = dt0[TagW+3:4];

  logic unused;
  assign unused = ^{dv1, dv2, dt1, dt2, mxv};
endmodule
`default_nettype wire

@@ rtl/amaq_quat.sv @@
// Rotation matrix to quaternion: branch select, root, off-diagonal divides.
`default_nettype none
module amaq_quat #(
  parameter int unsigned FracBits = 15
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic signed [FracBits+2:0]  m [9],
  input  wire logic                        degen_in,
  output logic                             out_valid,
  output amaq_pkg::quat_t                  quat
);
  import amaq_pkg::*;
  localparam int unsigned UW = FracBits + 3;
  localparam int unsigned TW = FracBits + 5;
  // root input width is a multiple of four so every radicand bit is consumed
  localparam int unsigned SqIn = 4 * ((TW + FracBits + 3) / 4);
  localparam int unsigned RtW = SqIn / 2;
  localparam int unsigned DW = FracBits + 5;
  localparam int unsigned NumW = DW + FracBits + 1;
  localparam int unsigned DenW = RtW + 2;
  localparam int unsigned QsW = NumW + 1;
  // tag: degen, axis(2, 3 = trace branch), spare(1), diffs 3 x signed (DW+1)
  localparam int unsigned TagW = 4 + 3 * (DW + 1);

  // stage A: trace, axis choice, t and differences
  logic signed [TW-1:0] tr, tt, one;
  logic [1:0] ax;
  logic signed [DW:0] d0, d1, d2;
  logic signed [UW-1:0] mii, mjj, mkk;
  assign one = TW'(1) <<< FracBits;
  always_comb begin
    tr = TW'(m[0]) + TW'(m[4]) + TW'(m[8]);
    ax = 2'd0;
    if (m[4] > m[0]) ax = 2'd1;
    if (m[8] > ((ax == 2'd1) ? m[4] : m[0])) ax = 2'd2;
    if (tr > 0) begin
      tt = tr + one;
      d0 = (DW+1)'(m[7]) - (DW+1)'(m[5]);
      d1 = (DW+1)'(m[2]) - (DW+1)'(m[6]);
      d2 = (DW+1)'(m[3]) - (DW+1)'(m[1]);
    end else begin
      case (ax)
        2'd0: begin
          mii = m[0]; mjj = m[4]; mkk = m[8];
          d0 = (DW+1)'(m[7]) - (DW+1)'(m[5]);
          d1 = (DW+1)'(m[3]) + (DW+1)'(m[1]);
          d2 = (DW+1)'(m[6]) + (DW+1)'(m[2]);
        end
        2'd1: begin
          mii = m[4]; mjj = m[8]; mkk = m[0];
          d0 = (DW+1)'(m[2]) - (DW+1)'(m[6]);
          d1 = (DW+1)'(m[7]) + (DW+1)'(m[5]);
          d2 = (DW+1)'(m[1]) + (DW+1)'(m[3]);
        end
        default: begin
          mii = m[8]; mjj = m[0]; mkk = m[4];
          d0 = (DW+1)'(m[3]) - (DW+1)'(m[1]);
          d1 = (DW+1)'(m[2]) + (DW+1)'(m[6]);
          d2 = (DW+1)'(m[5]) + (DW+1)'(m[7]);
        end
      endcase
      tt = TW'(mii) - TW'(mjj) - TW'(mkk) + one;
      if (tt < 0) tt = '0;
    end
    if (tr > 0) begin
      mii = '0; mjj = '0; mkk = '0;
    end
  end

  logic va;
  logic [SqIn-1:0] sx;
  logic [TagW-1:0] tga;
  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (en) va <= in_valid;
    if (en) begin
      sx <= SqIn'(unsigned'(tt)) << FracBits;
      tga <= {degen_in, (tr > 0) ? 2'd3 : ax, 1'b0,
              d0, d1, d2};
    end
  end

  logic vr;
  logic [RtW-1:0] rt;
  logic [TagW-1:0] tgr;
  amaq_isqrt #(.InW(SqIn), .TagW(TagW)) u_sqrt (
    .clk, .rst, .en, .in_valid(va), .x(sx), .tag_in(tga),
    .out_valid(vr), .root(rt), .tag_out(tgr));

  logic signed [DW:0] e0, e1, e2;
  assign e0 = tgr[3*(DW+1)-1 -: DW+1];
  assign e1 = tgr[2*(DW+1)-1 -: DW+1];
  assign e2 = tgr[DW:0];

  logic [DenW-1:0] den;
  assign den = (rt == '0) ? DenW'(2) : DenW'({rt, 1'b0});
  logic [NumW-1:0] nm0, nm1, nm2;
  logic [DW:0] a0, a1, a2;
  assign a0 = e0[DW] ? -e0 : e0;
  assign a1 = e1[DW] ? -e1 : e1;
  assign a2 = e2[DW] ? -e2 : e2;
  assign nm0 = NumW'({a0, FracBits'(0)}) + NumW'(rt);
  assign nm1 = NumW'({a1, FracBits'(0)}) + NumW'(rt);
  assign nm2 = NumW'({a2, FracBits'(0)}) + NumW'(rt);

  localparam int unsigned DtW = 4 + 3 + RtW;
  logic [DtW-1:0] dtin, dt0, dt1, dt2;
  assign dtin = {tgr[TagW-1 -: 4], e0[DW], e1[DW], e2[DW], rt};
  logic dv0, dv1, dv2;
  logic [NumW-1:0] q0, q1, q2;
  amaq_div #(.NumW(NumW), .DenW(DenW), .TagW(DtW)) u_d0 (
    .clk, .rst, .en, .in_valid(vr), .num(nm0), .den(den), .tag_in(dtin),
    .out_valid(dv0), .quo(q0), .tag_out(dt0));
  amaq_div #(.NumW(NumW), .DenW(DenW), .TagW(DtW)) u_d1 (
    .clk, .rst, .en, .in_valid(vr), .num(nm1), .den(den), .tag_in(dtin),
    .out_valid(dv1), .quo(q1), .tag_out(dt1));
  amaq_div #(.NumW(NumW), .DenW(DenW), .TagW(DtW)) u_d2 (
    .clk, .rst, .en, .in_valid(vr), .num(nm2), .den(den), .tag_in(dtin),
    .out_valid(dv2), .quo(q2), .tag_out(dt2));

  function automatic logic signed [QW-1:0] to_q15(input logic neg,
                                                  input logic [QsW-1:0] mg_in);
    logic [QsW-1:0] mg;
    mg = mg_in;
    if (FracBits >= 15) begin
      if (FracBits > 15) mg = QsW'((mg + (QsW'(1) << (FracBits - 16))) >> (FracBits - 15));
    end else begin
      if (mg > (QsW'(1) << 20)) mg = QsW'(1) << 20;
      mg = mg << (15 - FracBits);
    end
    if (mg > QsW'(32768)) mg = QsW'(32768);
    if (neg) to_q15 = QW'(-$signed({1'b0, mg}));
    else if (mg > QsW'(32767)) to_q15 = QW'(32767);
    else to_q15 = QW'(mg);
  endfunction

  // final stage: place components by axis and convert to Q1.15
  logic [RtW-1:0] rf;
  logic [1:0] axf;
  logic zr;
  logic signed [QW-1:0] mc, c0, c1, c2;
  assign rf = dt0[RtW-1:0];
  assign axf = dt0[DtW-2 -: 2];
  assign zr = (rf == '0);
  assign mc = to_q15(1'b0, QsW'((QsW'(rf) + QsW'(1)) >> 1));
  assign c0 = to_q15(dt0[RtW+2], QsW'(q0));
  assign c1 = to_q15(dt0[RtW+1], QsW'(q1));
  assign c2 = to_q15(dt0[RtW], QsW'(q2));

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= dv0;
    if (en) begin
      quat.degenerate <= dt0[DtW-1];
      if (dt0[DtW-1] || zr) begin
        quat.w <= '0; quat.x <= '0; quat.y <= '0; quat.z <= '0;
      end else begin
        case (axf)
          2'd3: begin quat.w <= mc; quat.x <= c0; quat.y <= c1; quat.z <= c2; end
          2'd0: begin quat.w <= c0; quat.x <= mc; quat.y <= c1; quat.z <= c2; end
          2'd1: begin quat.w <= c0; quat.y <= mc; quat.z <= c1; quat.x <= c2; end
          default: begin quat.w <= c0; quat.z <= mc; quat.x <= c1; quat.y <= c2; end
        endcase
      end
    end
  end

  logic unused;
  assign unused = ^{dv1, dv2, dt1, dt2, dt0[DtW-4]};
endmodule
`default_nettype wire

@@ rtl/accel_mag_attitude_quaternion.sv @@
// Top level: accelerometer + magnetometer pair to attitude quaternion.
// Accepts one sensor pair per clock unless stalled and returns one Q1.15
// quaternion per pair. At FRAC_BITS = 15 there are 116 register stages:
// 3 of cross products, 66 in the row normalizer (3, then 16 root stages,
// then 32 + FRAC_BITS divider stages) and 47 in the quaternion stage (1,
// then 9 root stages, then 2*FRAC_BITS + 6 divider stages, then the output
// register); the one-bit-per-stage restoring dividers make up most of them.
// The whole datapath advances on a single enable, held only when the output
// register is full and not taken.
`default_nettype none
module accel_mag_attitude_quaternion #(
  parameter int unsigned FRAC_BITS = 15
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // acc_x, acc_y, acc_z, mag_x, mag_y, mag_z (16 bits each)
  input  wire logic [95:0]  s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // quat_w, quat_x, quat_y, quat_z (16 bits each), degenerate, 7 zero bits
  output logic [71:0]       m_tdata
);
  import amaq_pkg::*;
  localparam int unsigned UW = FRAC_BITS + 3;

  logic en, acc;
  // pipeline moves whenever its output slot is free
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  assign acc = s_tvalid && s_tready;

  // stage 1: east cross product
  logic signed [AxisW-1:0] ax, ay, az, mx, my, mz;
  assign {mz, my, mx, az, ay, ax} = s_tdata;
  logic v1;
  logic signed [EastW-1:0] e0, e1, e2;
  logic signed [AxisW-1:0] a0, a1, a2;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= acc;
    if (en) begin
      e0 <= EastW'(ay * mz) - EastW'(az * my);
      e1 <= EastW'(az * mx) - EastW'(ax * mz);
      e2 <= EastW'(ax * my) - EastW'(ay * mx);
      a0 <= ax; a1 <= ay; a2 <= az;
    end
  end

  // stage 2: products for north
  logic v2;
  logic signed [NorthW-1:0] p [6];
  logic signed [EastW-1:0] e0r, e1r, e2r;
  logic signed [AxisW-1:0] a0r, a1r, a2r;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      p[0] <= NorthW'(e1 * a2); p[1] <= NorthW'(e2 * a1);
      p[2] <= NorthW'(e2 * a0); p[3] <= NorthW'(e0 * a2);
      p[4] <= NorthW'(e0 * a1); p[5] <= NorthW'(e1 * a0);
      e0r <= e0; e1r <= e1; e2r <= e2;
      a0r <= a0; a1r <= a1; a2r <= a2;
    end
  end

  // stage 3: north
  logic v3;
  logic signed [NorthW-1:0] n0, n1, n2, ee0, ee1, ee2, aa0, aa1, aa2;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      n0 <= p[0] - p[1]; n1 <= p[2] - p[3]; n2 <= p[4] - p[5];
      ee0 <= NorthW'(e0r); ee1 <= NorthW'(e1r); ee2 <= NorthW'(e2r);
      aa0 <= NorthW'(a0r); aa1 <= NorthW'(a1r); aa2 <= NorthW'(a2r);
    end
  end

  logic rv0, rv1, rv2, z0, z1, z2;
  logic signed [UW-1:0] m [9];
  logic [0:0] t0, t1, t2;
  amaq_unit_row #(.VecW(NorthW), .FracBits(FRAC_BITS), .TagW(1)) u_north (
    .clk, .rst, .en, .in_valid(v3), .v0(n0), .v1(n1), .v2(n2), .tag_in(1'b0),
    .out_valid(rv0), .u0(m[0]), .u1(m[1]), .u2(m[2]), .zero(z0), .tag_out(t0));
  amaq_unit_row #(.VecW(NorthW), .FracBits(FRAC_BITS), .TagW(1)) u_east (
    .clk, .rst, .en, .in_valid(v3), .v0(ee0), .v1(ee1), .v2(ee2), .tag_in(1'b0),
    .out_valid(rv1), .u0(m[3]), .u1(m[4]), .u2(m[5]), .zero(z1), .tag_out(t1));
  amaq_unit_row #(.VecW(NorthW), .FracBits(FRAC_BITS), .TagW(1)) u_down (
    .clk, .rst, .en, .in_valid(v3), .v0(aa0), .v1(aa1), .v2(aa2), .tag_in(1'b0),
    .out_valid(rv2), .u0(m[6]), .u1(m[7]), .u2(m[8]), .zero(z2), .tag_out(t2));

  quat_t q;
  logic qv;
  amaq_quat #(.FracBits(FRAC_BITS)) u_quat (
    .clk, .rst, .en, .in_valid(rv0), .m(m), .degen_in(z0 || z1 || z2),
    .out_valid(qv), .quat(q));

  assign m_tvalid = qv;
  assign m_tdata = {7'b0, q.degenerate, q.z, q.y, q.x, q.w};

  logic unused;
  assign unused = ^{rv1, rv2, t0, t1, t2};
endmodule
`default_nettype wire

@@ rtl/amaq_checker.sv @@
// Port-level checker for the attitude quaternion block, bound to the top.
`default_nettype none
module amaq_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [71:0] m_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output");
  a_degen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[64] |-> m_tdata[63:0] == 64'd0)
    else $error("degenerate result with nonzero quaternion");
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[71:65] == 7'd0)
    else $error("pad bits set");
endmodule

bind accel_mag_attitude_quaternion amaq_checker u_amaq_checker (
  .clk, .rst, .s_tready, .m_tvalid, .m_tready, .m_tdata);
`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the accel/mag attitude quaternion block.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import amaq_pkg::*;

  localparam int FracBits = 15;
  localparam int CycleLimit = 2000000;
  localparam int DrainCycles = 400;

  typedef struct {
    shortint w, x, y, z;
    bit      degenerate;
  } attitude_t;

  // Computes the expected quaternion for each accepted sensor pair and
  // checks the block's results against them in order.
  class attitude_scoreboard;
    attitude_t pending_q[$];
    int mismatches = 0;
    int matched = 0;

    static function automatic longint unsigned abs64(longint v);
      return v < 0 ? longint'(0) - v : v;
    endfunction

    static function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    static function automatic longint round_div(longint num, longint unsigned den);
      longint unsigned q;
      q = (abs64(num) + den / 2) / den;
      return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    // Scales a vector to a unit row in Q(FracBits); zero norm returns 0.
    static function automatic bit unit_vec(input longint v [3], output longint u [3]);
      longint unsigned mg [3];
      longint unsigned mx = 0, s = 0, n, q;
      int k = 0;
      for (int i = 0; i < 3; i++) begin
        mg[i] = abs64(v[i]);
        if (mg[i] > mx) mx = mg[i];
      end
      while ((mx >> k) >= (64'd1 << 31)) k++;
      for (int i = 0; i < 3; i++) begin
        mg[i] >>= k;
        s += mg[i] * mg[i];
      end
      n = int_sqrt(s);
      for (int i = 0; i < 3; i++) u[i] = 0;
      if (n == 0) return 0;
      for (int i = 0; i < 3; i++) begin
        q = ((mg[i] << FracBits) + n / 2) / n;
        u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 1;
    endfunction

    static function automatic shortint sat_q15(longint v);
      longint unsigned mg;
      longint r;
      mg = abs64(v);
      if (mg > 32768) mg = 32768;
      r = v < 0 ? -longint'(mg) : longint'(mg);
      if (r > 32767) r = 32767;
      return shortint'(r);
    endfunction

    static function automatic attitude_t predict(logic [95:0] d);
      longint a [3], m [3], e [3], nv [3], r0 [3], r1 [3], r2 [3];
      longint mat [3][3];
      longint q [4];
      longint one, tr, t;
      longint unsigned r;
      int i, j, k;
      bit ok;
      attitude_t res;
      one = longint'(1) << FracBits;
      for (int c = 0; c < 3; c++) begin
        a[c] = longint'($signed(d[16*c +: 16]));
        m[c] = longint'($signed(d[48 + 16*c +: 16]));
      end
      e[0] = a[1] * m[2] - a[2] * m[1];
      e[1] = a[2] * m[0] - a[0] * m[2];
      e[2] = a[0] * m[1] - a[1] * m[0];
      nv[0] = e[1] * a[2] - e[2] * a[1];
      nv[1] = e[2] * a[0] - e[0] * a[2];
      nv[2] = e[0] * a[1] - e[1] * a[0];
      ok = unit_vec(nv, r0);
      if (ok) ok = unit_vec(e, r1);
      if (ok) ok = unit_vec(a, r2);
      res = '{0, 0, 0, 0, 1'b0};
      if (!ok) begin
        res.degenerate = 1'b1;
        return res;
      end
      for (int c = 0; c < 3; c++) begin
        mat[0][c] = r0[c];
        mat[1][c] = r1[c];
        mat[2][c] = r2[c];
      end
      for (int c = 0; c < 4; c++) q[c] = 0;
      tr = mat[0][0] + mat[1][1] + mat[2][2];
      if (tr > 0) begin
        r = int_sqrt(longint'(tr + one) << FracBits);
        q[0] = longint'((r + 1) / 2);
        q[1] = round_div((mat[2][1] - mat[1][2]) * one, 2 * r);
        q[2] = round_div((mat[0][2] - mat[2][0]) * one, 2 * r);
        q[3] = round_div((mat[1][0] - mat[0][1]) * one, 2 * r);
      end else begin
        i = 0;
        if (mat[1][1] > mat[0][0]) i = 1;
        if (mat[2][2] > mat[i][i]) i = 2;
        j = (i + 1) % 3;
        k = (j + 1) % 3;
        t = mat[i][i] - mat[j][j] - mat[k][k] + one;
        if (t < 0) t = 0;
        r = int_sqrt(t << FracBits);
        if (r != 0) begin
          q[1 + i] = longint'((r + 1) / 2);
          q[0] = round_div((mat[k][j] - mat[j][k]) * one, 2 * r);
          q[1 + j] = round_div((mat[j][i] + mat[i][j]) * one, 2 * r);
          q[1 + k] = round_div((mat[k][i] + mat[i][k]) * one, 2 * r);
        end
      end
      res.w = sat_q15(q[0]);
      res.x = sat_q15(q[1]);
      res.y = sat_q15(q[2]);
      res.z = sat_q15(q[3]);
      return res;
    endfunction

    function void note_request(logic [95:0] d);
      pending_q.push_back(predict(d));
    endfunction

    function void check_result(logic [71:0] d);
      attitude_t exp_q, got;
      got.w = d[15:0];
      got.x = d[31:16];
      got.y = d[47:32];
      got.z = d[63:48];
      got.degenerate = d[64];
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", d);
        return;
      end
      exp_q = pending_q.pop_front();
      if (exp_q.w != got.w || exp_q.x != got.x || exp_q.y != got.y ||
          exp_q.z != got.z || exp_q.degenerate != got.degenerate) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp w=%0d x=%0d y=%0d z=%0d dg=%0b, got w=%0d x=%0d y=%0d z=%0d dg=%0b",
                   exp_q.w, exp_q.x, exp_q.y, exp_q.z, exp_q.degenerate,
                   got.w, got.x, got.y, got.z, got.degenerate);
      end else begin
        matched++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [95:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [71:0] m_tdata;

  attitude_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int requests_sent = 0;
  int cycle_count = 0;

  accel_mag_attitude_quaternion #(.FRAC_BITS(FracBits)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus long hold-offs requested by the main flow.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && s_tvalid && s_tready) sb.note_request(s_tdata);
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_pair(input shortint ax, ay, az, mx, my, mz);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {mz, my, mx, az, ay, ax};
    do @(posedge clk); while (!s_tready);
    requests_sent++;
  endtask

  task automatic send_random(input int count);
    shortint v [6];
    for (int n = 0; n < count; n++) begin
      for (int c = 0; c < 6; c++) begin
        case ($urandom_range(9))
          0: v[c] = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
          1: v[c] = shortint'($urandom_range(8)) - 16'sd4;
          default: v[c] = shortint'($urandom());
        endcase
      end
      // occasionally make m parallel to a, or zero a vector
      if ($urandom_range(19) == 0) begin
        v[3] = v[0]; v[4] = v[1]; v[5] = v[2];
      end else if ($urandom_range(29) == 0) begin
        v[0] = 0; v[1] = 0; v[2] = 0;
      end
      send_pair(v[0], v[1], v[2], v[3], v[4], v[5]);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending_q.size() != 0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: degenerate inputs; trace, axis-0 and axis-2 branch frames
    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(0, 0, 1000, 0, 0, 0);
    send_pair(0, 0, 0, 1000, 0, 0);
    send_pair(500, 500, 500, 1000, 1000, 1000);
    send_pair(-32768, -32768, -32768, -32768, -32768, -32768);
    send_pair(0, 0, 1000, 1000, 0, 0);
    send_pair(0, 0, -1000, 1000, 0, 0);
    send_pair(0, 0, 1000, -1000, 0, 0);
    send_pair(0, 0, 1000, 0, 1000, 0);
    send_pair(1000, 0, 0, 0, 0, 1000);
    send_pair(0, 1000, 0, 0, 0, 1000);
    send_pair(-1000, 0, 0, 0, 1000, 0);
    send_pair(0, -1000, 0, 1000, 0, 0);
    send_pair(32767, 0, 0, 0, 32767, 0);
    send_pair(-32768, 0, 0, 0, -32768, 0);
    send_pair(32767, 32767, 32767, -32768, 32767, -32768);
    send_pair(-32768, 32767, -32768, 32767, -32768, 32767);
    send_pair(1, 0, 0, 0, 1, 0);
    send_pair(1, 1, 1, -1, 0, 1);
    send_pair(0, 0, 1, 1, 0, 0);
    send_pair(100, -200, 9800, 300, 200, -400);
    wait_drained();

    send_random(120);
    send_idle_pct = 86;
    send_random(110);
    send_idle_pct = 0;
    recv_stall_pct = 86;
    send_random(110);

    // long receiver hold-off while requests keep coming, to fill the pipeline
    recv_stall_pct = 0;
    hold_cycles = 400;
    send_random(100);
    wait_drained();

    send_idle_pct = 9;
    recv_stall_pct = 9;
    send_random(120);
    wait_drained();

    repeat (DrainCycles) @(posedge clk);
    $display("Covered %0d sensor pairs (%0d results matched), directed frames plus",
             requests_sent, sb.matched);
    $display("random pairs under idle, stall and back-pressure phases.");
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending_q.size());
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
rtl/amaq_pkg.sv
rtl/amaq_isqrt.sv
rtl/amaq_div.sv
rtl/amaq_unit_row.sv
rtl/amaq_quat.sv
rtl/accel_mag_attitude_quaternion.sv
rtl/amaq_checker.sv
verif/tb_top.sv
